FILE: rtl/core/systick_timer_with_register_space_unit_macros.svh
// assertion macros shared by the systick timer checker
`ifndef SYSTICK_TIMER_WITH_REGISTER_SPACE_UNIT_MACROS_SVH
`define SYSTICK_TIMER_WITH_REGISTER_SPACE_UNIT_MACROS_SVH

// implication checked on every clock edge outside reset
`define STK_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// condition in one cycle implies a consequence in the next
`define STK_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

FILE: rtl/core/stk_pkg.sv
// shared types, widths and constants of the systick timer
`default_nettype none

package stk_pkg;

    // field widths
    localparam int ACT_W  = 2;
    localparam int ADDR_W = 32;
    localparam int SIZE_W = 3;
    localparam int DATA_W = 32;

    // default configuration
    localparam int unsigned STORE_WORDS_DEF  = 1024;
    localparam int unsigned SLOW_DIVIDER_DEF = 8;

    // request codes
    localparam logic [ACT_W-1:0] ACT_READ  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_WRITE = 2'd1;
    localparam logic [ACT_W-1:0] ACT_TICK  = 2'd2;

    // register window: 4 KiB page, word index within it
    localparam int                  WIN_WORD_BITS = 10;
    localparam logic [19:0]         WIN_PAGE      = 20'hE000E;
    localparam logic [WIN_WORD_BITS-1:0] W_CTRL   = 10'h004;
    localparam logic [WIN_WORD_BITS-1:0] W_LOAD   = 10'h005;
    localparam logic [WIN_WORD_BITS-1:0] W_VAL    = 10'h006;
    localparam logic [WIN_WORD_BITS-1:0] W_CALIB  = 10'h007;
    localparam logic [WIN_WORD_BITS-1:0] W_IDENT  = 10'h340;
    localparam logic [WIN_WORD_BITS-1:0] W_SCTRL  = 10'h345;

    localparam logic [DATA_W-1:0] IDENT_RESET = 32'h411F_C272;
    localparam logic [DATA_W-1:0] SCTRL_RESET = 32'h0000_0200;

    // control register bits
    localparam int CTRL_W      = 3;
    localparam int CNT_W       = 24;
    localparam int CTRL_ENABLE = 0;
    localparam int CTRL_TICKIE = 1;
    localparam int CTRL_CLKSRC = 2;
    localparam int FLAG_POS    = 16;

endpackage

`default_nettype wire

FILE: rtl/core/stk_ifs.sv
// request and response channel interfaces of the systick timer
`default_nettype none

interface stk_req_if;
    import stk_pkg::*;

    logic              valid;
    logic              ready;
    logic [ACT_W-1:0]  action;
    logic [ADDR_W-1:0] address;
    logic [SIZE_W-1:0] size;
    logic [DATA_W-1:0] wdata;

    modport source (output valid, action, address, size, wdata, input ready);
    modport sink   (input valid, action, address, size, wdata, output ready);
endinterface

interface stk_rsp_if;
    import stk_pkg::*;

    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] rdata;
    logic              irq_pulse;

    modport source (output valid, rdata, irq_pulse, input ready);
    modport sink   (input valid, rdata, irq_pulse, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/stk_ram.sv
// generic simple dual-port ram with registered read
`default_nettype none

module stk_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/systick_timer_with_register_space_unit.sv
// systick timer top level: 24-bit down counter with byte-lane register window
// a request is registered in stage 1 and its result then in the response register
// throughput: one request per cycle while the response is taken; the store
//   read-modify-write is split over the ram's registered read and a bypass
//   register, so back-to-back hits are fine
// reset: synchronous, active low; afterwards the store is initialised by a
//   clearing pass over all STORE_WORDS words during which no request is accepted
`default_nettype none

module systick_timer_with_register_space_unit #(
    parameter int unsigned STORE_WORDS  = stk_pkg::STORE_WORDS_DEF,
    parameter int unsigned SLOW_DIVIDER = stk_pkg::SLOW_DIVIDER_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    stk_req_if.sink    i_req,
    stk_rsp_if.source  o_rsp
);
    import stk_pkg::*;

    localparam int AW = $clog2(STORE_WORDS);
    localparam int PW = $clog2(SLOW_DIVIDER);
    localparam logic [AW-1:0]            CLR_LAST  = AW'(STORE_WORDS - 1);
    localparam logic [PW-1:0]            PRE_LAST  = PW'(SLOW_DIVIDER - 1);
    localparam logic [WIN_WORD_BITS:0]   STORE_LIM = (WIN_WORD_BITS + 1)'(STORE_WORDS);

    // byte-lane merge of write data into an old word
    function automatic logic [DATA_W-1:0] lane_merge(
        input logic [DATA_W-1:0] old_word,
        input logic [DATA_W-1:0] new_word,
        input logic [DATA_W-1:0] mask
    );
        return (old_word & ~mask) | (new_word & mask);
    endfunction

    // ------------------------------------------------------------------
    // request register (stage 1)
    // ------------------------------------------------------------------
    logic              r_s1_v;
    logic [ACT_W-1:0]  r_s1_action;
    logic [ADDR_W-1:0] r_s1_addr;
    logic [SIZE_W-1:0] r_s1_size;
    logic [DATA_W-1:0] r_s1_wdata;

    // timer state
    logic [CTRL_W-1:0] r_ctrl, n_ctrl;
    logic [CNT_W-1:0]  r_reload, n_reload;
    logic [CNT_W-1:0]  r_count, n_count;
    logic              r_flag, n_flag;
    logic [PW-1:0]     r_presc, n_presc;

    // store clearing pass after reset
    logic          r_clearing;
    logic [AW-1:0] r_clr_idx;

    // last store write, covers the read issued in the same cycle
    logic              r_byp_v;
    logic [AW-1:0]     r_byp_addr;
    logic [DATA_W-1:0] r_byp_data;

    // response register
    logic              r_o_v;
    logic [DATA_W-1:0] r_o_rdata;
    logic              r_o_irq;

    // handshake: stage 1 moves on whenever the response slot is free or leaving
    logic s1_adv;
    logic req_acc;

    assign s1_adv      = r_s1_v && (!r_o_v || o_rsp.ready);
    assign i_req.ready = !r_clearing && (!r_s1_v || s1_adv);
    assign req_acc     = i_req.valid && i_req.ready;

    // ------------------------------------------------------------------
    // address decode and lane masks of the request in stage 1
    // ------------------------------------------------------------------
    logic [11:0]              s1_off;
    logic [WIN_WORD_BITS-1:0] s1_word;
    logic                     s1_in_win;
    logic                     s1_size_ok;
    logic                     s1_bus_ok;
    logic                     s1_in_store;
    logic [3:0]               s1_base_lanes;
    logic [3:0]               s1_lanes;
    logic [DATA_W-1:0]        s1_mask;
    logic [4:0]               s1_sh;
    logic [DATA_W-1:0]        s1_wsh;
    logic [AW-1:0]            s1_ram_addr;

    assign s1_off      = r_s1_addr[11:0];
    assign s1_word     = s1_off[11:2];
    assign s1_in_win   = r_s1_addr[ADDR_W-1:12] == WIN_PAGE;
    // a request must not run past its word
    assign s1_size_ok  = (r_s1_size != '0) &&
                         ((4'(r_s1_size) + 4'(s1_off[1:0])) <= 4'd4);
    assign s1_bus_ok   = s1_in_win && s1_size_ok;
    assign s1_in_store = {1'b0, s1_word} < STORE_LIM;
    assign s1_sh       = {s1_off[1:0], 3'b000};
    assign s1_wsh      = r_s1_wdata << s1_sh;
    assign s1_ram_addr = s1_word[AW-1:0];

    always_comb begin
        case (r_s1_size)
            3'd1:    s1_base_lanes = 4'b0001;
            3'd2:    s1_base_lanes = 4'b0011;
            3'd3:    s1_base_lanes = 4'b0111;
            3'd4:    s1_base_lanes = 4'b1111;
            default: s1_base_lanes = 4'b0000;
        endcase
        s1_lanes = s1_base_lanes << s1_off[1:0];
        for (int i = 0; i < 4; i++) begin
            s1_mask[8*i +: 8] = {8{s1_lanes[i]}};
        end
    end

    // ------------------------------------------------------------------
    // word store
    // ------------------------------------------------------------------
    logic [DATA_W-1:0] ram_q;
    logic [DATA_W-1:0] store_q;
    logic [DATA_W-1:0] store_rd;
    logic              st_we;
    logic [DATA_W-1:0] st_wdata;
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [DATA_W-1:0] ram_wdata;
    logic [DATA_W-1:0] clr_data;
    logic              s1_store_word;

    assign store_q  = (r_byp_v && (r_byp_addr == s1_ram_addr)) ? r_byp_data : ram_q;
    assign store_rd = s1_in_store ? store_q : '0;

    // identity, calibration and the timer registers never land in the store
    assign s1_store_word = (s1_word != W_CTRL) && (s1_word != W_LOAD) &&
                           (s1_word != W_VAL) && (s1_word != W_CALIB) &&
                           (s1_word != W_IDENT);

    assign st_we    = s1_adv && (r_s1_action == ACT_WRITE) && s1_bus_ok &&
                      s1_store_word && s1_in_store;
    assign st_wdata = lane_merge(store_q, s1_wsh, s1_mask);

    // reset contents, selected by the full word index
    always_comb begin
        if (WIN_WORD_BITS'(r_clr_idx) == W_IDENT) begin
            clr_data = IDENT_RESET;
        end else if (WIN_WORD_BITS'(r_clr_idx) == W_SCTRL) begin
            clr_data = SCTRL_RESET;
        end else begin
            clr_data = '0;
        end
    end

    assign ram_we    = r_clearing || st_we;
    assign ram_waddr = r_clearing ? r_clr_idx : s1_ram_addr;
    assign ram_wdata = r_clearing ? clr_data : st_wdata;

    stk_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STORE_WORDS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (req_acc),
        .i_raddr (i_req.address[AW+1:2]),
        .o_rdata (ram_q)
    );

    // ------------------------------------------------------------------
    // read data
    // ------------------------------------------------------------------
    logic [DATA_W-1:0] rd_word;
    logic [DATA_W-1:0] rd_data;

    always_comb begin
        unique case (s1_word)
            W_CTRL: begin
                rd_word = '0;
                rd_word[CTRL_W-1:0] = r_ctrl;
                rd_word[FLAG_POS]   = r_flag;
            end
            W_LOAD:  rd_word = DATA_W'(r_reload);
            W_VAL:   rd_word = DATA_W'(r_count);
            default: rd_word = store_rd;
        endcase
    end

    assign rd_data = (rd_word & s1_mask) >> s1_sh;

    // ------------------------------------------------------------------
    // tick: prescaler, down counter and wrap detection
    // ------------------------------------------------------------------
    logic             tk_take;
    logic             tk_wrap;
    logic [CNT_W-1:0] tk_count;

    // counter takes a step on every core tick, or on the last of each slow period
    assign tk_take = r_ctrl[CTRL_ENABLE] && (r_ctrl[CTRL_CLKSRC] || (r_presc == PRE_LAST));

    always_comb begin
        tk_wrap  = 1'b0;
        tk_count = r_count;
        if (r_count == '0) begin
            // zero reload keeps wrapping on every step
            if (r_reload == '0) begin
                tk_wrap = 1'b1;
            end else begin
                tk_count = r_reload;
            end
        end else if (r_count == CNT_W'(1)) begin
            tk_count = '0;
            tk_wrap  = 1'b1;
        end else begin
            tk_count = r_count - CNT_W'(1);
        end
    end

    // ------------------------------------------------------------------
    // architectural state update
    // ------------------------------------------------------------------
    logic [DATA_W-1:0] ctrl_merged;
    logic [DATA_W-1:0] load_merged;
    logic [CNT_W-1:0]  load_new;
    logic              n_irq;
    logic [DATA_W-1:0] n_rdata;

    assign ctrl_merged = lane_merge(DATA_W'(r_ctrl), s1_wsh, s1_mask);
    assign load_merged = lane_merge(DATA_W'(r_reload), s1_wsh, s1_mask);
    assign load_new    = load_merged[CNT_W-1:0];

    always_comb begin
        n_ctrl   = r_ctrl;
        n_reload = r_reload;
        n_count  = r_count;
        n_flag   = r_flag;
        n_presc  = r_presc;
        n_irq    = 1'b0;
        n_rdata  = '0;
        case (r_s1_action)
            ACT_TICK: begin
                if (!r_ctrl[CTRL_ENABLE] || r_ctrl[CTRL_CLKSRC] || tk_take) begin
                    n_presc = '0;
                end else begin
                    n_presc = r_presc + PW'(1);
                end
                if (tk_take) begin
                    n_count = tk_count;
                    if (tk_wrap) begin
                        n_flag = 1'b1;
                        n_irq  = r_ctrl[CTRL_TICKIE];
                    end
                end
            end
            ACT_READ: begin
                if (s1_bus_ok) begin
                    n_rdata = rd_data;
                    // reading control consumes the count flag
                    if (s1_word == W_CTRL) begin
                        n_flag = 1'b0;
                    end
                end
            end
            ACT_WRITE: begin
                if (s1_bus_ok) begin
                    unique case (s1_word)
                        W_CTRL: begin
                            n_ctrl  = ctrl_merged[CTRL_W-1:0];
                            n_presc = '0;
                        end
                        W_LOAD: begin
                            n_reload = load_new;
                            n_count  = (r_count > load_new) ? load_new : r_count;
                            n_presc  = '0;
                        end
                        W_VAL: begin
                            n_count = '0;
                            n_flag  = 1'b0;
                            n_presc = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            default: begin
            end
        endcase
    end

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v     <= 1'b0;
            r_o_v      <= 1'b0;
            r_byp_v    <= 1'b0;
            r_clearing <= 1'b1;
            r_clr_idx  <= '0;
            r_ctrl     <= '0;
            r_reload   <= '0;
            r_count    <= '0;
            r_flag     <= 1'b0;
            r_presc    <= '0;
        end else begin
            // clearing pass
            if (r_clearing) begin
                r_clr_idx <= r_clr_idx + AW'(1);
                if (r_clr_idx == CLR_LAST) begin
                    r_clearing <= 1'b0;
                end
            end

            // request register
            if (req_acc) begin
                r_s1_v <= 1'b1;
            end else if (s1_adv) begin
                r_s1_v <= 1'b0;
            end

            // state and response slot
            if (s1_adv) begin
                r_ctrl   <= n_ctrl;
                r_reload <= n_reload;
                r_count  <= n_count;
                r_flag   <= n_flag;
                r_presc  <= n_presc;
                r_byp_v  <= st_we;
                r_o_v    <= 1'b1;
            end else if (o_rsp.ready) begin
                r_o_v <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (req_acc) begin
            r_s1_action <= i_req.action;
            r_s1_addr   <= i_req.address;
            r_s1_size   <= i_req.size;
            r_s1_wdata  <= i_req.wdata;
        end
        if (s1_adv) begin
            r_o_rdata  <= n_rdata;
            r_o_irq    <= n_irq;
            r_byp_addr <= s1_ram_addr;
            r_byp_data <= st_wdata;
        end
    end

    assign o_rsp.valid     = r_o_v;
    assign o_rsp.rdata     = r_o_rdata;
    assign o_rsp.irq_pulse = r_o_irq;

endmodule

`default_nettype wire

FILE: rtl/core/stk_checker.sv
// port-level checker of the systick timer and its bind
`default_nettype none

`include "systick_timer_with_register_space_unit_macros.svh"

module stk_checker (
    input wire logic                      i_clk,
    input wire logic                      i_rst_n,
    input wire logic                      i_req_valid,
    input wire logic                      i_req_ready,
    input wire logic                      i_rsp_valid,
    input wire logic                      i_rsp_ready,
    input wire logic [stk_pkg::DATA_W-1:0] i_rsp_rdata,
    input wire logic                      i_rsp_irq_pulse
);
    import stk_pkg::*;

    // stalled response stays offered
    `STK_ASSERT_NEXT(a_rsp_hold, i_clk, i_rst_n, i_rsp_valid && !i_rsp_ready, i_rsp_valid, "response dropped under stall")

    // stalled response keeps its data
    `STK_ASSERT_NEXT(a_rsp_stable, i_clk, i_rst_n, i_rsp_valid && !i_rsp_ready, $stable(i_rsp_rdata) && $stable(i_rsp_irq_pulse), "response changed under stall")

    // an interrupt only comes from a tick, which reads nothing
    `STK_ASSERT(a_irq_no_data, i_clk, i_rst_n, (i_rsp_valid && i_rsp_irq_pulse) |-> (i_rsp_rdata == '0), "interrupt response with read data")

    // a fresh response follows a request that was accepted and passed through stage 1
    `STK_ASSERT(a_rsp_latency, i_clk, i_rst_n, $rose(i_rsp_valid) |-> $past(i_req_valid && i_req_ready, 2), "response without matching request")

    // store initialisation blocks requests right after reset
    `STK_ASSERT(a_clear_after_reset, i_clk, i_rst_n, !$past(i_rst_n) |-> (!i_req_ready && !i_rsp_valid), "request taken during clearing pass")

endmodule

bind systick_timer_with_register_space_unit stk_checker u_stk_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_req_valid     (i_req.valid),
    .i_req_ready     (i_req.ready),
    .i_rsp_valid     (o_rsp.valid),
    .i_rsp_ready     (o_rsp.ready),
    .i_rsp_rdata     (o_rsp.rdata),
    .i_rsp_irq_pulse (o_rsp.irq_pulse)
);

`default_nettype wire
